@@ sv/sohc_pkg.sv @@
// ---------------------------------------------------------------------------
// sohc_pkg : shared types and constants of the solenoid open/hold controller
// Phase and opcode codes, register indexes, scaling constants and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package sohc_pkg;

  // opcodes of an input request
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // valve phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_START_OPEN = 3'd1;
  localparam logic [2:0] PH_OPENING    = 3'd2;
  localparam logic [2:0] PH_OPEN       = 3'd3;
  localparam logic [2:0] PH_START_CLS  = 3'd4;
  localparam logic [2:0] PH_CLOSED     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_TARGET = 3'd0;
  localparam logic [2:0] CFG_MAX_TARGET = 3'd1;
  localparam logic [2:0] CFG_MIN_TO     = 3'd2;
  localparam logic [2:0] CFG_RETENTION  = 3'd3;
  localparam logic [2:0] CFG_BLANK      = 3'd4;
  localparam logic [2:0] CFG_MIN_RISE   = 3'd5;

  // scaling and control constants
  localparam logic [12:0] DUTY_MAX     = 13'd4875;
  localparam logic [10:0] VNOM         = 11'd400;
  localparam logic [13:0] CUR_SCALE    = 14'd9768;
  localparam logic [10:0] VOLT_SCALE   = 11'd1033;
  localparam logic [10:0] HOLD_KNEE    = 11'd750;
  localparam logic [12:0] HOLD_BASE    = 13'd300;
  localparam logic [10:0] TGT_STEP_DN  = 11'd10;
  localparam logic [11:0] TGT_STEP_UP  = 12'd50;
  localparam logic [15:0] HOLD_PERIOD  = 16'd10;
  localparam logic [11:0] CHG_HYST     = 12'd10;

  // divider widths
  localparam int unsigned DVD_W = 34;
  localparam int unsigned DSR_W = 11;

  // controller -> datapath commands
  typedef struct packed {
    logic ld_in;
    logic do_scale;
    logic do_filt;
    logic do_phase;
    logic do_out;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_req;
    logic div_done;
  } status_t;

endpackage

@@ sv/sohc_div.sv @@
// ---------------------------------------------------------------------------
// sohc_div : restoring serial divider
// One quotient bit per cycle.
// ---------------------------------------------------------------------------
module sohc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sohc_pkg::DVD_W-1:0]      dividend_i,
  input  logic [sohc_pkg::DSR_W-1:0]      divisor_i,
  output logic                            done_o,
  output logic [sohc_pkg::DVD_W-1:0]      quotient_o
);

  localparam logic [5:0] LAST = 6'(sohc_pkg::DVD_W - 1);

  logic                          busy_q, done_q;
  logic [5:0]                    cnt_q;
  logic [sohc_pkg::DVD_W-1:0]    dq_q;
  logic [sohc_pkg::DSR_W-1:0]    rem_q, dsr_q;
  logic [sohc_pkg::DSR_W:0]      rem_sh;
  logic                          ge;
  logic [sohc_pkg::DSR_W:0]      rem_sub;

  // one restoring step
  assign rem_sh  = {rem_q, dq_q[sohc_pkg::DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[sohc_pkg::DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[sohc_pkg::DSR_W-1:0] : rem_sh[sohc_pkg::DSR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

@@ sv/sohc_dp.sv @@
// ---------------------------------------------------------------------------
// sohc_dp : datapath of the solenoid open/hold controller
// Scaling, averaging filter, charge sum, phase logic, target adaption and
// the result snapshot; blanking time and capacitance via the serial divider.
// ---------------------------------------------------------------------------
module sohc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sohc_pkg::cmd_t        cmd_i,
  output sohc_pkg::status_t     status_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic [1:0]            opcode_i,
  input  logic [11:0]           current_code_i,
  input  logic [11:0]           supply_code_i,
  output logic [2:0]            valve_state_o,
  output logic [12:0]           pwm_duty_o,
  output logic                  driver_on_o,
  output logic                  charger_on_o,
  output logic [15:0]           capacitance_o,
  output logic [10:0]           target_voltage_o,
  output logic [15:0]           active_time_o,
  output logic signed [14:0]    current_rise_o
);

  // configuration
  logic [10:0] min_tgt_q, max_tgt_q;
  logic [15:0] min_to_q, ret_q, blank_dly_q;
  logic [14:0] min_rise_q;

  // input and scaled samples
  logic [1:0]  op_q;
  logic [11:0] ccode_q, scode_q;
  logic [13:0] cur_q;
  logic [10:0] volt_q;

  // state
  logic [2:0]         phase_q;
  logic [15:0]        timer_q, mark_q, move_time_q, blank_q, open_lim_q;
  logic               moved_q;
  logic signed [15:0] peak_q, thr_q, rise_q;
  logic [31:0]        csum_q;
  logic [10:0]        sv_q, target_q;
  logic [15:0]        acc_q;
  logic [13:0]        avg_q;
  logic [15:0]        cap_q, active_q;
  logic [12:0]        duty_q;
  logic               drive_q, chg_q, sel_cap_q;

  // divider interface
  logic                        div_start, div_done;
  logic [sohc_pkg::DVD_W-1:0]  div_dvd, div_q;
  logic [sohc_pkg::DSR_W-1:0]  div_dsr;

  // scaling products
  logic [25:0] cur_prod;
  logic [22:0] volt_prod;
  assign cur_prod  = ccode_q * sohc_pkg::CUR_SCALE;
  assign volt_prod = scode_q * sohc_pkg::VOLT_SCALE;

  // filter update
  logic [15:0]        acc_n;
  logic [13:0]        avg_n;
  logic signed [15:0] rise_n;
  assign acc_n  = acc_q + {2'b0, cur_q} - {2'b0, avg_q};
  assign avg_n  = acc_n[15:2];
  assign rise_n = $signed({2'b0, cur_q}) - $signed({2'b0, avg_n});

  // charger hysteresis thresholds
  logic [11:0] tgt_hi;
  assign tgt_hi = {1'b0, target_q} + sohc_pkg::CHG_HYST;

  // opening phase: peak tracking and move detection
  logic               peak_upd, move_hit, timed_out, end_hit;
  logic signed [15:0] peak_n, thr_n;
  logic [16:0]        ret_end;
  logic signed [16:0] thr_x2;
  logic               moved_n;
  logic [15:0]        move_time_n;
  assign peak_upd   = !moved_q && (rise_q > peak_q);
  assign peak_n     = peak_upd ? rise_q : peak_q;
  assign thr_n      = peak_upd ? (rise_q >>> 2) : thr_q;
  assign move_hit   = !moved_q && (timer_q >= blank_q) &&
                      (peak_n >= $signed({1'b0, min_rise_q})) && (rise_q < thr_n);
  assign moved_n    = moved_q || move_hit;
  assign move_time_n = move_hit ? timer_q : move_time_q;
  assign ret_end    = {1'b0, move_time_n} + {1'b0, ret_q};
  assign thr_x2     = {thr_n, 1'b0};
  assign timed_out  = timer_q >= open_lim_q;
  assign end_hit    = timed_out || (moved_n && ({1'b0, timer_q} >= ret_end) &&
                      ($signed({rise_q[15], rise_q}) > thr_x2));

  // hold duty
  logic [15:0] mark_n;
  logic [12:0] hold_duty;
  assign mark_n    = (mark_q != 16'hFFFF) ? mark_q + 16'd1 : mark_q;
  assign hold_duty = (volt_q < sohc_pkg::HOLD_KNEE) ?
                     sohc_pkg::HOLD_BASE + {2'b0, sohc_pkg::HOLD_KNEE - volt_q} :
                     sohc_pkg::HOLD_BASE;

  // open timeout from a blanking time
  function automatic logic [15:0] open_limit_f(input logic [15:0] blank,
                                               input logic [15:0] min_to);
    logic [16:0] lim;
    lim = {blank, 1'b0};
    if (lim < {1'b0, min_to}) lim = {1'b0, min_to};
    return lim[16] ? 16'hFFFF : lim[15:0];
  endfunction

  // target adaption at end of opening
  logic [10:0] tgt_dn, tgt_new;
  logic [11:0] tgt_up;
  assign tgt_dn = (target_q > sohc_pkg::TGT_STEP_DN) ? target_q - sohc_pkg::TGT_STEP_DN : '0;
  assign tgt_up = {1'b0, target_q} + sohc_pkg::TGT_STEP_UP;
  always_comb begin
    tgt_new = target_q;
    if (!timed_out) begin
      if (target_q > min_tgt_q) tgt_new = tgt_dn;
    end else if (target_q <= max_tgt_q) begin
      tgt_new = tgt_up[11] ? 11'h7FF : tgt_up[10:0];
    end
  end

  // divider requests
  logic is_tick, blank_div, cap_div;
  assign is_tick   = (op_q == sohc_pkg::OP_TICK);
  assign blank_div = cmd_i.do_phase && is_tick && (phase_q == sohc_pkg::PH_START_OPEN) &&
                     (volt_q > sohc_pkg::VNOM);
  assign cap_div   = cmd_i.do_phase && is_tick && (phase_q == sohc_pkg::PH_OPENING) &&
                     end_hit && (sv_q > volt_q);
  assign div_start = blank_div || cap_div;
  assign div_dvd   = blank_div ? sohc_pkg::DVD_W'(blank_dly_q * sohc_pkg::VNOM)
                               : ({2'b0, csum_q} + {1'b0, csum_q, 1'b0});
  assign div_dsr   = blank_div ? volt_q : sv_q - volt_q;

  sohc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign status_o.div_req  = div_start;
  assign status_o.div_done = div_done;

  // input capture and scaling
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q    <= opcode_i;
      ccode_q <= current_code_i;
      scode_q <= supply_code_i;
    end
    if (cmd_i.do_scale) begin
      cur_q  <= cur_prod[25:12];
      volt_q <= volt_prod[22:12];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tgt_q   <= 11'd450;
      max_tgt_q   <= 11'd750;
      min_to_q    <= 16'd60;
      ret_q       <= 16'd5;
      blank_dly_q <= 16'd75;
      min_rise_q  <= 15'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sohc_pkg::CFG_MIN_TARGET: min_tgt_q   <= cfg_wdata_i[10:0];
        sohc_pkg::CFG_MAX_TARGET: max_tgt_q   <= cfg_wdata_i[10:0];
        sohc_pkg::CFG_MIN_TO:     min_to_q    <= cfg_wdata_i;
        sohc_pkg::CFG_RETENTION:  ret_q       <= cfg_wdata_i;
        sohc_pkg::CFG_BLANK:      blank_dly_q <= cfg_wdata_i;
        sohc_pkg::CFG_MIN_RISE:   min_rise_q  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // valve state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sohc_pkg::PH_IDLE;
      timer_q     <= '0;
      mark_q      <= '0;
      moved_q     <= 1'b0;
      move_time_q <= '0;
      blank_q     <= '0;
      open_lim_q  <= '0;
      peak_q      <= '0;
      thr_q       <= '0;
      rise_q      <= '0;
      csum_q      <= '0;
      sv_q        <= '0;
      acc_q       <= '0;
      avg_q       <= '0;
      target_q    <= 11'd700;
      cap_q       <= '0;
      active_q    <= '0;
      duty_q      <= '0;
      drive_q     <= 1'b0;
      chg_q       <= 1'b0;
      sel_cap_q   <= 1'b0;
    end else begin
      // sample update or command
      if (cmd_i.do_filt) begin
        case (op_q)
          sohc_pkg::OP_TICK: begin
            acc_q  <= acc_n;
            avg_q  <= avg_n;
            rise_q <= rise_n;
            csum_q <= csum_q + {18'b0, cur_q};
            if (timer_q != 16'hFFFF) timer_q <= timer_q + 16'd1;
            if ({1'b0, volt_q} >= tgt_hi) chg_q <= 1'b1;
            else if (volt_q <= target_q) chg_q <= 1'b0;
          end
          sohc_pkg::OP_OPEN: begin
            if (phase_q == sohc_pkg::PH_IDLE || phase_q > sohc_pkg::PH_OPEN)
              phase_q <= sohc_pkg::PH_START_OPEN;
          end
          sohc_pkg::OP_CLOSE: begin
            if (phase_q != sohc_pkg::PH_START_CLS && phase_q != sohc_pkg::PH_CLOSED) begin
              duty_q  <= '0;
              drive_q <= 1'b0;
              phase_q <= sohc_pkg::PH_START_CLS;
            end
          end
          default: ;
        endcase
      end

      // phase machine on a tick
      if (cmd_i.do_phase && is_tick) begin
        case (phase_q)
          sohc_pkg::PH_START_OPEN: begin
            timer_q     <= '0;
            duty_q      <= sohc_pkg::DUTY_MAX;
            drive_q     <= 1'b1;
            csum_q      <= '0;
            sv_q        <= volt_q;
            moved_q     <= 1'b0;
            move_time_q <= '0;
            peak_q      <= '0;
            thr_q       <= '0;
            phase_q     <= sohc_pkg::PH_OPENING;
            sel_cap_q   <= 1'b0;
            if (!(volt_q > sohc_pkg::VNOM)) begin
              blank_q    <= blank_dly_q;
              open_lim_q <= open_limit_f(blank_dly_q, min_to_q);
            end
          end
          sohc_pkg::PH_OPENING: begin
            peak_q      <= peak_n;
            thr_q       <= thr_n;
            moved_q     <= moved_n;
            move_time_q <= move_time_n;
            if (end_hit) begin
              duty_q    <= '0;
              target_q  <= tgt_new;
              phase_q   <= sohc_pkg::PH_OPEN;
              active_q  <= timer_q;
              timer_q   <= '0;
              mark_q    <= '0;
              sel_cap_q <= 1'b1;
            end
          end
          sohc_pkg::PH_OPEN: begin
            if (mark_n >= sohc_pkg::HOLD_PERIOD) begin
              mark_q <= '0;
              duty_q <= hold_duty;
            end else begin
              mark_q <= mark_n;
            end
          end
          sohc_pkg::PH_START_CLS: begin
            timer_q <= '0;
            duty_q  <= '0;
            drive_q <= 1'b0;
            phase_q <= sohc_pkg::PH_CLOSED;
          end
          default: timer_q <= '0;
        endcase
      end

      // divider results
      if (div_done) begin
        if (sel_cap_q) begin
          cap_q <= (|div_q[33:18]) ? 16'hFFFF : div_q[17:2];
        end else begin
          blank_q    <= div_q[15:0];
          open_lim_q <= open_limit_f(div_q[15:0], min_to_q);
        end
      end
    end
  end

  // result snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_out) begin
      valve_state_o    <= phase_q;
      pwm_duty_o       <= duty_q;
      driver_on_o      <= drive_q;
      charger_on_o     <= chg_q;
      capacitance_o    <= cap_q;
      target_voltage_o <= target_q;
      active_time_o    <= active_q;
      current_rise_o   <= rise_q[14:0];
    end
  end

endmodule

@@ sv/sohc_ctrl.sv @@
// ---------------------------------------------------------------------------
// sohc_ctrl : sequencing controller
// Steps each request through capture, scaling, filter, phase logic and an
// optional divide, then hands the result to the output register.
// ---------------------------------------------------------------------------
module sohc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sohc_pkg::cmd_t     cmd_o,
  input  sohc_pkg::status_t  status_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_FILT, S_PHASE, S_DIV, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // command decode
  assign cmd_o.ld_in    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.do_scale = (state_q == S_SCALE);
  assign cmd_o.do_filt  = (state_q == S_FILT);
  assign cmd_o.do_phase = (state_q == S_PHASE);
  assign cmd_o.do_out   = (state_q == S_OUT) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCALE;
      S_SCALE: state_d = S_FILT;
      S_FILT:  state_d = S_PHASE;
      S_PHASE: state_d = status_i.div_req ? S_DIV : S_OUT;
      S_DIV:   if (status_i.div_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.do_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // checks
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_req_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_req |-> (state_q == S_PHASE))
    else $error("divide requested outside phase step");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_in |=> (state_q == S_SCALE))
    else $error("accepted request not processed");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

@@ sv/solenoid_open_hold_controller.sv @@
// ---------------------------------------------------------------------------
// solenoid_open_hold_controller : solenoid valve open/hold controller
// Drives a solenoid from open, close and sample-tick requests.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a tick with
//   raw coil current and supply ADC codes, an open or a close command.
//   Output channel (out_valid_o / out_stall_i) returns one result per request:
//   phase, PWM duty, driver and charger enables, capacitance estimate, charger
//   target, last opening time and current rise.
//   Most requests go through capture, scaling, filter and phase steps to the
//   result; a tick that starts opening above nominal supply or ends opening
//   with a supply drop also runs the serial divider. One request is in work at
//   a time, so a new request is taken only once the last one has reached the
//   output step and been handed on.
//   A finished result sits in the output register; the next request is taken
//   while it waits. If the receiver keeps stalling, the following result waits
//   in the datapath and the input stalls until the register frees.
//   Reset: idle phase, target 700, all estimates zero, registers at defaults.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once;
//   the user must make them while no request is in work (not enforced here).
// ---------------------------------------------------------------------------
module solenoid_open_hold_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [11:0]        current_code_i,
  input  logic [11:0]        supply_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         valve_state_o,
  output logic [12:0]        pwm_duty_o,
  output logic               driver_on_o,
  output logic               charger_on_o,
  output logic [15:0]        capacitance_o,
  output logic [10:0]        target_voltage_o,
  output logic [15:0]        active_time_o,
  output logic signed [14:0] current_rise_o
);

  sohc_pkg::cmd_t    cmd;
  sohc_pkg::status_t status;

  // sequencing
  sohc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // arithmetic and state
  sohc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .current_code_i   (current_code_i),
    .supply_code_i    (supply_code_i),
    .valve_state_o    (valve_state_o),
    .pwm_duty_o       (pwm_duty_o),
    .driver_on_o      (driver_on_o),
    .charger_on_o     (charger_on_o),
    .capacitance_o    (capacitance_o),
    .target_voltage_o (target_voltage_o),
    .active_time_o    (active_time_o),
    .current_rise_o   (current_rise_o)
  );

endmodule

@@ tb/sv/solenoid_open_hold_controller_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// solenoid_open_hold_controller_test : self-checking bench of the valve block
// Sends open, close and tick requests through the valid/stall channel,
// predicts each status result in the bench and compares every field. A short
// directed table comes first, then random open/hold/close sequences under
// several register settings and with both sides idling and stalling.
// ---------------------------------------------------------------------------
module solenoid_open_hold_controller_test;

  localparam int unsigned STUCK_LIMIT = 5000;

  // one status result of the block
  typedef struct packed {
    logic [2:0]  phase;
    logic [12:0] duty;
    logic        drive;
    logic        charge;
    logic [15:0] cap;
    logic [10:0] target;
    logic [15:0] active;
    logic [14:0] rise;
  } valve_report_t;

  // one row of the directed table
  typedef struct {
    logic [1:0]    op;
    logic [11:0]   cur;
    logic [11:0]   sup;
    bit            typed;
    valve_report_t rep;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = '0;
  logic [11:0]        current_code_i = '0;
  logic [11:0]        supply_code_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         valve_state_o;
  logic [12:0]        pwm_duty_o;
  logic               driver_on_o;
  logic               charger_on_o;
  logic [15:0]        capacitance_o;
  logic [10:0]        target_voltage_o;
  logic [15:0]        active_time_o;
  logic signed [14:0] current_rise_o;

  solenoid_open_hold_controller u_top (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted register copy
  longint min_tgt, max_tgt, min_open_to, retention, blank_delay, min_rise;
  // predicted valve state
  longint phase, phase_timer, hold_mark, moved, move_time, blank_time, open_limit;
  longint rise_peak, rise_thr, last_rise, charge_sum, start_volt, avg_acc, avg_cur;
  longint target, cap, active, duty, drive, charge_en;

  valve_report_t expected_reports[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_in = 0, idle_out = 0;
  bit            hold_off_req = 1'b0;
  int unsigned   stuck_cycles = 0;

  function automatic void clip_duty(longint v);
    duty = (v < sohc_pkg::DUTY_MAX) ? v : sohc_pkg::DUTY_MAX;
  endfunction

  // next status of the valve for one request
  function automatic valve_report_t step_valve(logic [1:0] op, logic [11:0] cc,
                                               logic [11:0] sc);
    longint cur, volt, lim, c;
    bit timed_out;
    valve_report_t r;
    if (op == sohc_pkg::OP_TICK) begin
      cur = (longint'(cc) * sohc_pkg::CUR_SCALE) >> 12;
      volt = (longint'(sc) * sohc_pkg::VOLT_SCALE) >> 12;
      avg_acc = (avg_acc + cur - avg_cur) & 64'hFFFF;
      avg_cur = avg_acc >> 2;
      last_rise = cur - avg_cur;
      charge_sum = (charge_sum + cur) & 64'hFFFF_FFFF;
      if (phase_timer < 65535) phase_timer++;
      // charger hysteresis on the present target
      if (volt >= target + sohc_pkg::CHG_HYST) charge_en = 1;
      else if (volt <= target) charge_en = 0;
      case (phase)
        sohc_pkg::PH_START_OPEN: begin
          phase_timer = 0;
          clip_duty(sohc_pkg::DUTY_MAX);
          drive = 1;
          charge_sum = 0;
          start_volt = volt;
          moved = 0;
          move_time = 0;
          blank_time = (volt > sohc_pkg::VNOM) ? (blank_delay * sohc_pkg::VNOM) / volt
                                               : blank_delay;
          lim = blank_time * 2;
          if (lim < min_open_to) lim = min_open_to;
          open_limit = (lim > 65535) ? 65535 : lim;
          rise_peak = 0;
          rise_thr = 0;
          phase = sohc_pkg::PH_OPENING;
        end
        sohc_pkg::PH_OPENING: begin
          if (!moved && last_rise > rise_peak) begin
            rise_peak = last_rise;
            rise_thr = rise_peak / 4;
          end
          if (!moved && phase_timer >= blank_time && rise_peak >= min_rise &&
              last_rise < rise_thr) begin
            moved = 1;
            move_time = phase_timer;
          end
          timed_out = phase_timer >= open_limit;
          if (timed_out || (moved && phase_timer >= move_time + retention &&
                            last_rise > rise_thr * 2)) begin
            clip_duty(0);
            // capacitance only when the supply sagged
            if (start_volt > volt) begin
              c = (charge_sum * 3) / (start_volt - volt) / 4;
              cap = (c > 65535) ? 65535 : c;
            end
            if (!timed_out) begin
              if (target > min_tgt)
                target = (target > sohc_pkg::TGT_STEP_DN) ? target - sohc_pkg::TGT_STEP_DN : 0;
            end else if (target <= max_tgt) begin
              target += sohc_pkg::TGT_STEP_UP;
              if (target > 2047) target = 2047;
            end
            phase = sohc_pkg::PH_OPEN;
            active = phase_timer;
            phase_timer = 0;
            hold_mark = 0;
          end
        end
        sohc_pkg::PH_OPEN: begin
          if (hold_mark < 65535) hold_mark++;
          if (hold_mark >= sohc_pkg::HOLD_PERIOD) begin
            hold_mark = 0;
            clip_duty((volt < sohc_pkg::HOLD_KNEE) ?
                      sohc_pkg::HOLD_BASE + (sohc_pkg::HOLD_KNEE - volt) : sohc_pkg::HOLD_BASE);
          end
        end
        sohc_pkg::PH_START_CLS: begin
          phase_timer = 0;
          clip_duty(0);
          drive = 0;
          phase = sohc_pkg::PH_CLOSED;
        end
        default: phase_timer = 0;
      endcase
    end else if (op == sohc_pkg::OP_OPEN) begin
      if (phase < sohc_pkg::PH_START_OPEN || phase > sohc_pkg::PH_OPEN)
        phase = sohc_pkg::PH_START_OPEN;
    end else if (op == sohc_pkg::OP_CLOSE) begin
      if (phase != sohc_pkg::PH_START_CLS && phase != sohc_pkg::PH_CLOSED) begin
        clip_duty(0);
        drive = 0;
        phase = sohc_pkg::PH_START_CLS;
      end
    end
    r.phase = 3'(phase);
    r.duty = 13'(duty);
    r.drive = 1'(drive);
    r.charge = 1'(charge_en);
    r.cap = 16'(cap);
    r.target = 11'(target);
    r.active = 16'(active);
    r.rise = 15'(last_rise);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // offer one request and record its expected status once accepted
  task automatic send_request(logic [1:0] op, logic [11:0] cc, logic [11:0] sc,
                              bit typed = 1'b0, valve_report_t rep = '0);
    valve_report_t r;
    while ($urandom_range(99) < idle_in) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    current_code_i = cc;
    supply_code_i = sc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = step_valve(op, cc, sc);
    expected_reports.push_back(typed ? rep : r);
    @(negedge clk_i);
  endtask

  // register write while nothing is in work
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    in_valid_i = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      sohc_pkg::CFG_MIN_TARGET: min_tgt = val & 16'h7FF;
      sohc_pkg::CFG_MAX_TARGET: max_tgt = val & 16'h7FF;
      sohc_pkg::CFG_MIN_TO:     min_open_to = val;
      sohc_pkg::CFG_RETENTION:  retention = val;
      sohc_pkg::CFG_BLANK:      blank_delay = val;
      sohc_pkg::CFG_MIN_RISE:   min_rise = val & 16'h7FFF;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] v0, v1, v2, v3, v4, v5);
    write_reg(sohc_pkg::CFG_MIN_TARGET, v0);
    write_reg(sohc_pkg::CFG_MAX_TARGET, v1);
    write_reg(sohc_pkg::CFG_MIN_TO, v2);
    write_reg(sohc_pkg::CFG_RETENTION, v3);
    write_reg(sohc_pkg::CFG_BLANK, v4);
    write_reg(sohc_pkg::CFG_MIN_RISE, v5);
  endtask

  // one open/hold/close sequence: current climbs, dips, climbs again
  task automatic open_sequence(ref int unsigned sent);
    int unsigned n, climb, dip;
    int cc, sc;
    n = $urandom_range(8, 40);
    climb = $urandom_range(1, 8);
    dip = climb + $urandom_range(1, 6);
    cc = $urandom_range(0, 300);
    sc = $urandom_range(1000, 2400);
    send_request(sohc_pkg::OP_OPEN, 12'($urandom), 12'($urandom));
    sent++;
    for (int unsigned k = 0; k < n; k++) begin
      if (k < climb) cc += $urandom_range(150, 800);
      else if (k < dip) cc -= $urandom_range(100, 700);
      else cc += $urandom_range(0, 400);
      if (cc < 0) cc = 0;
      if (cc > 4095) cc = 4095;
      sc -= $urandom_range(0, 40);
      if (sc < 0) sc = 0;
      if ($urandom_range(19) == 0)
        send_request(2'($urandom_range(3)), 12'($urandom), 12'($urandom));
      else
        send_request(sohc_pkg::OP_TICK, 12'(cc), 12'(sc));
      sent++;
    end
    if ($urandom_range(3) != 0) begin
      send_request(sohc_pkg::OP_CLOSE, 12'($urandom), 12'($urandom));
      send_request(sohc_pkg::OP_TICK, 12'($urandom), 12'($urandom));
      sent += 2;
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall_i = ($urandom_range(99) < idle_out);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    valve_report_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: status with nothing expected", $realtime);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (valve_state_o !== want.phase) report_mismatch("valve_state", valve_state_o, want.phase);
        if (pwm_duty_o !== want.duty) report_mismatch("pwm_duty", pwm_duty_o, want.duty);
        if (driver_on_o !== want.drive) report_mismatch("driver_on", driver_on_o, want.drive);
        if (charger_on_o !== want.charge)
          report_mismatch("charger_on", charger_on_o, want.charge);
        if (capacitance_o !== want.cap) report_mismatch("capacitance", capacitance_o, want.cap);
        if (target_voltage_o !== want.target)
          report_mismatch("target_voltage", target_voltage_o, want.target);
        if (active_time_o !== want.active)
          report_mismatch("active_time", active_time_o, want.active);
        if (current_rise_o !== want.rise)
          report_mismatch("current_rise", current_rise_o, $signed(want.rise));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("solenoid_open_hold_controller_test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows[$];
    valve_report_t rep;
    int unsigned sent, total;

    // reset state of the predictor
    min_tgt = 450; max_tgt = 750; min_open_to = 60; retention = 5;
    blank_delay = 75; min_rise = 200;
    phase = sohc_pkg::PH_IDLE; phase_timer = 0; hold_mark = 0; moved = 0;
    move_time = 0; blank_time = 0; open_limit = 0; rise_peak = 0; rise_thr = 0;
    last_rise = 0; charge_sum = 0; start_volt = 0; avg_acc = 0; avg_cur = 0;
    target = 700; cap = 0; active = 0; duty = 0; drive = 0; charge_en = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table; first rows typed from the reset state
    rep = '{phase: sohc_pkg::PH_START_CLS, target: 11'd700, default: '0};
    rows.push_back('{sohc_pkg::OP_CLOSE, 12'd0, 12'd0, 1'b1, rep});
    rows.push_back('{2'd3, 12'hFFF, 12'hFFF, 1'b1, rep});
    rep.phase = sohc_pkg::PH_CLOSED;
    rows.push_back('{sohc_pkg::OP_TICK, 12'd0, 12'd0, 1'b1, rep});
    rows.push_back('{sohc_pkg::OP_OPEN, 12'd0, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'hFFF, 12'hFFF, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'hFFF, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'd0, 12'd2000, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_OPEN, 12'd5, 12'd5, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_CLOSE, 12'd0, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_CLOSE, 12'd0, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_OPEN, 12'd0, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'd800, 12'd1000, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'd3000, 12'd2816, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'd100, 12'd2775, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'hAAA, 12'h555, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'h555, 12'hAAA, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_CLOSE, 12'd0, 12'd0, 1'b0, '0});
    rows.push_back('{sohc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0, '0});
    foreach (rows[i]) send_request(rows[i].op, rows[i].cur, rows[i].sup, rows[i].typed,
                                   rows[i].rep);

    // random part: settings from near-default values to the extremes, then random
    total = 0;
    for (int unsigned setting = 0; setting < 5; setting++) begin
      case (setting)
        0: write_all(16'd450, 16'd750, 16'd30, 16'd2, 16'd8, 16'd200);
        1: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: write_all(16'd0, 16'h7FF, 16'd1, 16'd0, 16'd0, 16'h7FFF);
        3: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: write_all(16'($urandom), 16'($urandom_range(400, 900)),
                           16'($urandom_range(5, 60)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 30)), 16'($urandom_range(0, 1500)));
      endcase
      sent = 0;
      while (sent < 100) begin
        // receiver busy first, then sender, then neither
        if (total + sent < 170) begin idle_in = 25; idle_out = 45; end
        else if (total + sent < 340) begin idle_in = 45; idle_out = 25; end
        else begin idle_in = 0; idle_out = 0; end
        if (setting == 4 && sent == 0) hold_off_req = 1'b1;
        if ($urandom_range(9) < 8) begin
          open_sequence(sent);
        end else begin
          send_request(2'($urandom_range(3)), 12'($urandom), 12'($urandom));
          sent++;
        end
      end
      total += sent;
    end
    in_valid_i = 1'b0;

    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0)
      $display("solenoid_open_hold_controller_test passed");
    else
      $display("solenoid_open_hold_controller_test failed");
    $finish;
  end

endmodule
